### hdl/wps_pkg.sv
// Shared types, constants and controller codes for the window pair-sum and range search unit.
package wps_pkg;

    localparam int WINDOW     = 25;
    localparam int MAX_ITEMS  = 4096;
    localparam int VALUE_W    = 62;
    localparam int ADDR_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int SUM_W      = VALUE_W + 2;

    localparam logic [CNT_W-1:0] WINDOW_C    = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0] MAX_ITEMS_C = CNT_W'(MAX_ITEMS);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               is_last;
    } in_item_t;

    typedef struct packed {
        logic               invalid_found;
        logic [VALUE_W-1:0] invalid_value;
        logic               range_found;
        logic [VALUE_W-1:0] range_min;
        logic [VALUE_W-1:0] range_max;
        logic [VALUE_W:0]   min_plus_max;
        logic               overflow;
    } out_item_t;

    typedef enum logic [4:0] {
        S_LOAD,
        S_P_INIT,
        S_P_CHK,
        S_P_TGT,
        S_I_CHK,
        S_I_CAP,
        S_J_CHK,
        S_J_CMP,
        S_R_INIT,
        S_R_SUM0,
        S_R_CHK,
        S_R_E_CHK,
        S_R_E_ADD,
        S_R_S_SUB,
        S_K_CHK,
        S_K_UPD,
        S_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_STORE,
        OP_P_INIT,
        OP_RD_TGT,
        OP_CAP_TGT,
        OP_RD_I,
        OP_CAP_I,
        OP_RD_J,
        OP_NEXT_J,
        OP_NEXT_I,
        OP_NEXT_P,
        OP_FOUND_INV,
        OP_R_INIT,
        OP_CAP_SUM,
        OP_E_INC,
        OP_RD_E,
        OP_ADD_E,
        OP_RD_S,
        OP_SUB_S,
        OP_K_INIT,
        OP_RD_K,
        OP_UPD_K,
        OP_RANGE_OK,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic p_lt_cnt;
        logic i_lt_p;
        logic j_lt_p;
        logic pair_hit;
        logic win_empty;
        logic sum_eq;
        logic sum_lt;
        logic e_ge_cnt;
        logic k_le_e;
        logic out_busy;
    } status_t;

endpackage

### hdl/wps_ctrl.sv
// Controller state machine: sequences loading, the pair check, the range scan and the result.
module wps_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load_valid,
    input  logic             load_last,
    output logic             load_ready,
    input  wps_pkg::status_t stat,
    output wps_pkg::cmd_t    cmd
);
    import wps_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        load_ready = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                load_ready = 1'b1;
                if (load_valid)
                begin
                    cmd.op = OP_STORE;
                    if (load_last)
                    begin
                        state_next = S_P_INIT;
                    end
                end
            end
            S_P_INIT:
            begin
                cmd.op     = OP_P_INIT;
                state_next = S_P_CHK;
            end
            S_P_CHK:
            begin
                if (stat.p_lt_cnt)
                begin
                    cmd.op     = OP_RD_TGT;
                    state_next = S_P_TGT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_P_TGT:
            begin
                cmd.op     = OP_CAP_TGT;
                state_next = S_I_CHK;
            end
            S_I_CHK:
            begin
                if (stat.i_lt_p)
                begin
                    cmd.op     = OP_RD_I;
                    state_next = S_I_CAP;
                end
                else
                begin
                    cmd.op     = OP_FOUND_INV;
                    state_next = S_R_INIT;
                end
            end
            S_I_CAP:
            begin
                cmd.op     = OP_CAP_I;
                state_next = S_J_CHK;
            end
            S_J_CHK:
            begin
                if (stat.j_lt_p)
                begin
                    cmd.op     = OP_RD_J;
                    state_next = S_J_CMP;
                end
                else
                begin
                    cmd.op     = OP_NEXT_I;
                    state_next = S_I_CHK;
                end
            end
            S_J_CMP:
            begin
                if (stat.pair_hit)
                begin
                    cmd.op     = OP_NEXT_P;
                    state_next = S_P_CHK;
                end
                else
                begin
                    cmd.op     = OP_NEXT_J;
                    state_next = S_J_CHK;
                end
            end
            S_R_INIT:
            begin
                cmd.op     = OP_R_INIT;
                state_next = S_R_SUM0;
            end
            S_R_SUM0:
            begin
                cmd.op     = OP_CAP_SUM;
                state_next = S_R_CHK;
            end
            S_R_CHK:
            begin
                priority if (!stat.win_empty && stat.sum_eq)
                begin
                    cmd.op     = OP_K_INIT;
                    state_next = S_K_CHK;
                end
                else if (stat.win_empty || stat.sum_lt)
                begin
                    cmd.op     = OP_E_INC;
                    state_next = S_R_E_CHK;
                end
                else
                begin
                    cmd.op     = OP_RD_S;
                    state_next = S_R_S_SUB;
                end
            end
            S_R_E_CHK:
            begin
                if (stat.e_ge_cnt)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = OP_RD_E;
                    state_next = S_R_E_ADD;
                end
            end
            S_R_E_ADD:
            begin
                cmd.op     = OP_ADD_E;
                state_next = S_R_CHK;
            end
            S_R_S_SUB:
            begin
                cmd.op     = OP_SUB_S;
                state_next = S_R_CHK;
            end
            S_K_CHK:
            begin
                if (stat.k_le_e)
                begin
                    cmd.op     = OP_RD_K;
                    state_next = S_K_UPD;
                end
                else
                begin
                    cmd.op     = OP_RANGE_OK;
                    state_next = S_FINISH;
                end
            end
            S_K_UPD:
            begin
                cmd.op     = OP_UPD_K;
                state_next = S_K_CHK;
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = OP_PUBLISH;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Publish only into a free result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PUBLISH) |-> !stat.out_busy)
        else $error("result published while previous result still waiting");

    // Loading accepts items only in the load state
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_STORE) |-> (load_ready && load_valid))
        else $error("store issued without an accepted item");

    // After the last item the search starts
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_valid && load_ready && load_last) |=> (state_reg == S_P_INIT))
        else $error("last item did not start the search");

endmodule

### hdl/wps_datapath.sv
// Datapath: number memory, scan pointers, sums, range statistics and the result register.
module wps_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  wps_pkg::cmd_t      cmd,
    output wps_pkg::status_t   stat,
    input  wps_pkg::in_item_t  load_item,
    output logic               result_valid,
    input  logic               result_ready,
    output wps_pkg::out_item_t result
);
    import wps_pkg::*;

    logic [VALUE_W-1:0] mem [MAX_ITEMS];
    logic [VALUE_W-1:0] rdata_reg;
    logic [ADDR_W-1:0]  raddr;
    logic               we;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic               result_valid_reg, result_valid_next;
    logic [CNT_W-1:0]   s_reg, s_next;
    logic [CNT_W-1:0]   e_reg, e_next;
    logic [CNT_W-1:0]   p_reg, p_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [VALUE_W-1:0] target_reg, target_next;
    logic [VALUE_W-1:0] a_reg, a_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [VALUE_W-1:0] rmin_reg, rmin_next;
    logic [VALUE_W-1:0] rmax_reg, rmax_next;
    logic               inv_found_reg, inv_found_next;
    logic [VALUE_W-1:0] inv_val_reg, inv_val_next;
    logic               rng_found_reg, rng_found_next;
    out_item_t          result_reg, result_next;
    logic [VALUE_W:0]   pair_sum;

    // Select the read address for this cycle
    always_comb
    begin
        unique case (cmd.op)
            OP_RD_TGT: raddr = p_reg[ADDR_W-1:0];
            OP_RD_I:   raddr = i_reg[ADDR_W-1:0];
            OP_RD_J:   raddr = j_reg[ADDR_W-1:0];
            OP_RD_E:   raddr = e_reg[ADDR_W-1:0];
            OP_RD_S:   raddr = s_reg[ADDR_W-1:0];
            OP_RD_K:   raddr = k_reg[ADDR_W-1:0];
            default:   raddr = '0;
        endcase
    end

    assign we = (cmd.op == OP_STORE) && (count_reg < MAX_ITEMS_C);

    // Number memory with registered read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[count_reg[ADDR_W-1:0]] <= load_item.value;
        end
        rdata_reg <= mem[raddr];
    end

    // Status toward the controller
    assign pair_sum      = {1'b0, a_reg} + {1'b0, rdata_reg};
    assign stat.p_lt_cnt = p_reg < count_reg;
    assign stat.i_lt_p   = i_reg < p_reg;
    assign stat.j_lt_p   = j_reg < p_reg;
    assign stat.pair_hit = pair_sum == {1'b0, target_reg};
    assign stat.win_empty = s_reg > e_reg;
    assign stat.sum_eq   = sum_reg == {2'b00, inv_val_reg};
    assign stat.sum_lt   = sum_reg < {2'b00, inv_val_reg};
    assign stat.e_ge_cnt = e_reg >= count_reg;
    assign stat.k_le_e   = k_reg <= e_reg;
    assign stat.out_busy = result_valid_reg && !result_ready;

    // Next values per command
    always_comb
    begin
        count_next        = count_reg;
        ovf_next          = ovf_reg;
        result_valid_next = result_valid_reg && !result_ready;
        s_next            = s_reg;
        e_next            = e_reg;
        p_next            = p_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        target_next       = target_reg;
        a_next            = a_reg;
        sum_next          = sum_reg;
        rmin_next         = rmin_reg;
        rmax_next         = rmax_reg;
        inv_found_next    = inv_found_reg;
        inv_val_next      = inv_val_reg;
        rng_found_next    = rng_found_reg;
        result_next       = result_reg;
        unique case (cmd.op)
            OP_STORE:
            begin
                if (count_reg < MAX_ITEMS_C)
                begin
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            OP_P_INIT:
            begin
                p_next         = WINDOW_C;
                inv_found_next = 1'b0;
                inv_val_next   = '0;
                rng_found_next = 1'b0;
                rmin_next      = '0;
                rmax_next      = '0;
            end
            OP_CAP_TGT:
            begin
                target_next = rdata_reg;
                i_next      = p_reg - WINDOW_C;
            end
            OP_CAP_I:
            begin
                a_next = rdata_reg;
                j_next = i_reg + 1'b1;
            end
            OP_NEXT_J:    j_next = j_reg + 1'b1;
            OP_NEXT_I:    i_next = i_reg + 1'b1;
            OP_NEXT_P:    p_next = p_reg + 1'b1;
            OP_FOUND_INV:
            begin
                inv_found_next = 1'b1;
                inv_val_next   = target_reg;
            end
            OP_R_INIT:
            begin
                s_next = '0;
                e_next = '0;
            end
            OP_CAP_SUM:   sum_next = {2'b00, rdata_reg};
            OP_E_INC:     e_next = e_reg + 1'b1;
            OP_ADD_E:     sum_next = sum_reg + {2'b00, rdata_reg};
            OP_SUB_S:
            begin
                sum_next = sum_reg - {2'b00, rdata_reg};
                s_next   = s_reg + 1'b1;
            end
            OP_K_INIT:
            begin
                k_next    = s_reg;
                rmin_next = '1;
                rmax_next = '0;
            end
            OP_UPD_K:
            begin
                if (rdata_reg < rmin_reg)
                begin
                    rmin_next = rdata_reg;
                end
                if (rdata_reg > rmax_reg)
                begin
                    rmax_next = rdata_reg;
                end
                k_next = k_reg + 1'b1;
            end
            OP_RANGE_OK:  rng_found_next = 1'b1;
            OP_PUBLISH:
            begin
                result_next.invalid_found = inv_found_reg;
                result_next.invalid_value = inv_val_reg;
                result_next.range_found   = rng_found_reg;
                result_next.range_min     = rmin_reg;
                result_next.range_max     = rmax_reg;
                result_next.min_plus_max  = {1'b0, rmin_reg} + {1'b0, rmax_reg};
                result_next.overflow      = ovf_reg;
                result_valid_next         = 1'b1;
                count_next                = '0;
                ovf_next                  = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            s_reg            <= '0;
            e_reg            <= '0;
        end
        else
        begin
            count_reg        <= count_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
            s_reg            <= s_next;
            e_reg            <= e_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        target_reg    <= target_next;
        a_reg         <= a_next;
        sum_reg       <= sum_next;
        rmin_reg      <= rmin_next;
        rmax_reg      <= rmax_next;
        inv_found_reg <= inv_found_next;
        inv_val_reg   <= inv_val_next;
        rng_found_reg <= rng_found_next;
        result_reg    <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Store fill never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_ITEMS_C)
        else $error("item count beyond capacity");

    // Scan start never runs past one beyond the scan end
    assert property (@(posedge clk) disable iff (!rst_n)
        s_reg <= (e_reg + 1'b1))
        else $error("range scan start passed end");

    // Publishing a result clears the sequence state
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PUBLISH) |=> (count_reg == '0 && !ovf_reg && result_valid_reg))
        else $error("publish did not clear sequence state");

    // Pair reads of the store stay above the first index and below the fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RD_J) |-> (j_reg > i_reg && j_reg < count_reg))
        else $error("pair read outside the window");

endmodule

### hdl/window_pair_sum_and_range_search_unit.sv
// Top level of the window pair-sum and range search unit.
// Items load at one per cycle into a 4096-entry store while in the load state; values past
// capacity are dropped and flagged. After the item marked last, the unit stops taking items
// and searches, with every step paced by the store's single read port and its registered
// read data. The pair check of an index stops early once a pair is found. The two-pointer
// scan reads one element to widen the run or to shrink it, and the min/max pass reads each
// run element in turn. The result is then placed in the output register, after which
// loading resumes while the result waits to be taken.
module window_pair_sum_and_range_search_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load_valid,
    output logic               load_ready,
    input  wps_pkg::in_item_t  load_item,
    output logic               result_valid,
    input  logic               result_ready,
    output wps_pkg::out_item_t result
);
    import wps_pkg::*;

    cmd_t    cmd;
    status_t stat;

    wps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (load_valid),
        .load_last  (load_item.is_last),
        .load_ready (load_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    wps_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .load_item    (load_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
